// File: src/bdlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdlp_pkg;

	localparam int DB_W   = 16;
	localparam int HOLD_W = 24;
	localparam int CFG_W  = 24;
	localparam int IN_W   = 8;
	localparam int OUT_W  = 32;

	localparam logic [DB_W-1:0]   DB_MAX   = '1;
	localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

	localparam logic [DB_W-1:0]   DB_RESET   = 16'd50;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 24'd1000;

	// output item bit positions
	localparam int O_PRESSED = 0;
	localparam int O_PRESS   = 1;
	localparam int O_LONG    = 2;
	localparam int O_RELEASE = 3;
	localparam int O_HELD_LO = 4;
	localparam int O_HELD_HI = O_HELD_LO + HOLD_W - 1;

	typedef enum logic {
		REG_DEBOUNCE_TICKS   = 1'b0,
		REG_LONG_PRESS_TICKS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [HOLD_W-1:0] held_ticks;
		logic              release_event;
		logic              long_press_event;
		logic              press_event;
		logic              is_pressed;
	} result_t;

endpackage

`default_nettype wire

// File: src/button_debounce_long_press.sv
`timescale 1ns / 1ps
`default_nettype none

// Debounced push button with press, long-press and release events. Each input item is one
// time tick carrying the raw pad level in bit 0; exactly one result item comes back per tick,
// holding the settled level, the three event flags and the hold duration. The block takes one
// tick every clock cycle: all counting and comparing for a tick happens in a single pass into
// the result register, and a new tick is taken whenever the result register is empty or being
// emptied in the same cycle. The first tick after reset seeds the settled level and hold count.
// The user writes limits through the cfg port while no tick is in flight; it is not enforced.

module button_debounce_long_press (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire bdlp_pkg::cfg_reg_t        cfg_addr,
	input  wire logic [bdlp_pkg::CFG_W-1:0] cfg_wdata,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [bdlp_pkg::IN_W-1:0]  s_axis_tdata,  // raw_level, zero pad
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	output logic [bdlp_pkg::OUT_W-1:0]      m_axis_tdata   // is_pressed, press_event,
	                                                       // long_press_event, release_event,
	                                                       // held_ticks, zero pad
);

	import bdlp_pkg::*;

	logic [DB_W-1:0]   debounce_ticks_q;
	logic [HOLD_W-1:0] long_press_ticks_q;

	logic              seeded_q;
	logic              settled_q;
	logic              long_fired_q;
	logic              db_run_q;
	logic [DB_W-1:0]   db_cnt_q;
	logic              hold_run_q;
	logic [HOLD_W-1:0] hold_cnt_q;

	logic              seeded_d;
	logic              settled_d;
	logic              long_fired_d;
	logic              db_run_d;
	logic [DB_W-1:0]   db_cnt_d;
	logic              hold_run_d;
	logic [HOLD_W-1:0] hold_cnt_d;
	logic [DB_W-1:0]   db_inc;
	logic              raw;
	logic              accept;

	result_t res_d;
	result_t res_q;

	assign raw           = s_axis_tdata[0];
	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign db_inc        = (db_cnt_q != DB_MAX) ? db_cnt_q + 1'b1 : db_cnt_q;

	always_comb begin
		seeded_d     = seeded_q;
		settled_d    = settled_q;
		long_fired_d = long_fired_q;
		db_run_d     = db_run_q;
		db_cnt_d     = db_cnt_q;
		hold_run_d   = hold_run_q;
		hold_cnt_d   = hold_cnt_q;
		res_d        = '0;

		if (hold_run_q && hold_cnt_q != HOLD_MAX) begin
			hold_cnt_d = hold_cnt_q + 1'b1;
		end

		if (!seeded_q) begin
			seeded_d  = 1'b1;
			settled_d = raw;
			db_run_d  = 1'b0;
			db_cnt_d  = '0;
			if (raw) begin
				hold_run_d   = 1'b1;
				hold_cnt_d   = '0;
				long_fired_d = 1'b0;
			end
		end else if (raw != settled_q) begin
			if (!db_run_q) begin
				db_run_d = 1'b1;
				db_cnt_d = '0;
			end else begin
				db_cnt_d = db_inc;
				if (db_inc >= debounce_ticks_q) begin
					settled_d = raw;
					db_run_d  = 1'b0;
					db_cnt_d  = '0;
					if (raw) begin
						hold_cnt_d        = '0;
						hold_run_d        = 1'b1;
						long_fired_d      = 1'b0;
						res_d.press_event = 1'b1;
					end else begin
						hold_run_d          = 1'b0;
						res_d.release_event = 1'b1;
					end
				end
			end
		end else begin
			db_run_d = 1'b0;
			db_cnt_d = '0;
			if (settled_q && !long_fired_q && hold_cnt_d >= long_press_ticks_q) begin
				long_fired_d           = 1'b1;
				res_d.long_press_event = 1'b1;
			end
		end

		res_d.is_pressed = settled_d;
		res_d.held_ticks = hold_cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q   <= DB_RESET;
			long_press_ticks_q <= HOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_DEBOUNCE_TICKS:   debounce_ticks_q   <= cfg_wdata[DB_W-1:0];
				REG_LONG_PRESS_TICKS: long_press_ticks_q <= cfg_wdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q     <= 1'b0;
			settled_q    <= 1'b0;
			long_fired_q <= 1'b0;
			db_run_q     <= 1'b0;
			db_cnt_q     <= '0;
			hold_run_q   <= 1'b0;
			hold_cnt_q   <= '0;
		end else if (accept) begin
			seeded_q     <= seeded_d;
			settled_q    <= settled_d;
			long_fired_q <= long_fired_d;
			db_run_q     <= db_run_d;
			db_cnt_q     <= db_cnt_d;
			hold_run_q   <= hold_run_d;
			hold_cnt_q   <= hold_cnt_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (s_axis_tready) begin
			m_axis_tvalid <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tdata = {{(OUT_W - $bits(result_t)){1'b0}}, res_q};

endmodule

`default_nettype wire

// File: src/bdlp_check.sv
`timescale 1ns / 1ps
`default_nettype none

module bdlp_check (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       m_axis_tvalid,
	input wire logic                       m_axis_tready,
	input wire logic [bdlp_pkg::OUT_W-1:0] m_axis_tdata
);

	import bdlp_pkg::*;

	// a press and a release never share one item
	a_press_xor_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[O_PRESS] && m_axis_tdata[O_RELEASE]))
		else $error("press and release in one item");

	// a press event leaves the button settled down with a fresh hold count
	a_press_state: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[O_PRESS]) |->
			(m_axis_tdata[O_PRESSED] && m_axis_tdata[O_HELD_HI:O_HELD_LO] == '0))
		else $error("press event without pressed level or zero hold count");

	a_release_state: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[O_RELEASE]) |-> !m_axis_tdata[O_PRESSED])
		else $error("release event while still pressed");

	a_long_state: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[O_LONG]) |->
			(m_axis_tdata[O_PRESSED] && !m_axis_tdata[O_PRESS]))
		else $error("long press while released or on the press item");

	// stalled item holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled item changed");

endmodule

bind button_debounce_long_press bdlp_check u_bdlp_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: bench/tb_button_debounce_long_press.sv
`timescale 1ns / 1ps

module tb_button_debounce_long_press;

	import bdlp_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	cfg_reg_t         cfg_addr = REG_DEBOUNCE_TICKS;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;   // raw_level, zero pad
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;        // is_pressed, press_event, long_press_event,
	                                  // release_event, held_ticks, zero pad

	button_debounce_long_press dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)
	);

	// button model state and limits
	logic              seeded = 1'b0;
	logic              settled = 1'b0;
	logic              long_done = 1'b0;
	logic              db_active = 1'b0;
	logic [DB_W-1:0]   db_cnt = '0;
	logic              hold_active = 1'b0;
	logic [HOLD_W-1:0] hold_cnt = '0;
	logic [DB_W-1:0]   db_limit = DB_RESET;
	logic [HOLD_W-1:0] long_limit = HOLD_RESET;

	bit      pending_levels[$];
	result_t expected_results[$];

	bit calm = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int errors = 0;
	int ticks_taken = 0;
	int results_checked = 0;
	int presses = 0;
	int long_presses = 0;
	int releases = 0;
	int settings_used = 1;
	bit last_level = 1'b0;

	int unsigned db_set [9] = '{0, 1, 2, 3, 20, 0, 16'hFFFF, 5, 1};
	int unsigned lp_set [9] = '{0, 2, 6, 15, 40, 24'hFFFFFF, 24'hFFFFFF, 30, 0};

	function automatic result_t debounce_tick(input logic raw);
		result_t r;
		r = '0;
		if (hold_active && hold_cnt != HOLD_MAX)
			hold_cnt = hold_cnt + 1'b1;
		if (!seeded) begin
			seeded = 1'b1;
			settled = raw;
			db_active = 1'b0;
			db_cnt = '0;
			if (raw) begin
				hold_active = 1'b1;
				hold_cnt = '0;
				long_done = 1'b0;
			end
		end else if (raw != settled) begin
			if (!db_active) begin
				db_active = 1'b1;
				db_cnt = '0;
			end else begin
				if (db_cnt != DB_MAX)
					db_cnt = db_cnt + 1'b1;
				if (db_cnt >= db_limit) begin
					settled = raw;
					db_active = 1'b0;
					db_cnt = '0;
					if (raw) begin
						hold_cnt = '0;
						hold_active = 1'b1;
						long_done = 1'b0;
						r.press_event = 1'b1;
					end else begin
						hold_active = 1'b0;
						r.release_event = 1'b1;
					end
				end
			end
		end else begin
			db_active = 1'b0;
			db_cnt = '0;
			if (settled && !long_done && hold_cnt >= long_limit) begin
				long_done = 1'b1;
				r.long_press_event = 1'b1;
			end
		end
		r.is_pressed = settled;
		r.held_ticks = hold_cnt;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	initial begin
		forever #10 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(debounce_tick(s_tdata[0]));
				ticks_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 || pending_levels.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= {{(IN_W-1){1'b0}}, pending_levels.pop_front()};
					gap_left = calm ? 0 : pick_gap();
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[O_HELD_HI:0];
				if (expected_results.size() == 0) begin
					$error("result item with no expected item pending");
					errors++;
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (want.press_event)
						presses++;
					if (want.long_press_event)
						long_presses++;
					if (want.release_event)
						releases++;
					if (got.is_pressed !== want.is_pressed) begin
						$error("is_pressed mismatch: expected %0d, got %0d",
							want.is_pressed, got.is_pressed);
						errors++;
					end
					if (got.press_event !== want.press_event) begin
						$error("press_event mismatch: expected %0d, got %0d",
							want.press_event, got.press_event);
						errors++;
					end
					if (got.long_press_event !== want.long_press_event) begin
						$error("long_press_event mismatch: expected %0d, got %0d",
							want.long_press_event, got.long_press_event);
						errors++;
					end
					if (got.release_event !== want.release_event) begin
						$error("release_event mismatch: expected %0d, got %0d",
							want.release_event, got.release_event);
						errors++;
					end
					if (got.held_ticks !== want.held_ticks) begin
						$error("held_ticks mismatch: expected %0d, got %0d",
							want.held_ticks, got.held_ticks);
						errors++;
					end
					if (m_tdata[OUT_W-1:O_HELD_HI+1] !== '0) begin
						$error("padding mismatch: expected 0, got %0h",
							m_tdata[OUT_W-1:O_HELD_HI+1]);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0)
					stall_left = pick_gap();
			end
		end
	end

	task automatic push_level(input bit lvl, input int n);
		repeat (n) pending_levels.push_back(lvl);
		last_level = lvl;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_levels.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t addr, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		if (addr == REG_DEBOUNCE_TICKS)
			db_limit = value[DB_W-1:0];
		else
			long_limit = value[HOLD_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// runs of one level: mostly long enough to commit, some glitches, some noise
	task automatic push_runs(input int n);
		int pushed;
		int len;
		int r;
		int span;
		int db_cap;
		bit lvl;
		pushed = 0;
		span = (long_limit > 37) ? 40 : int'(long_limit) + 3;
		db_cap = (db_limit > 40) ? 40 : int'(db_limit);
		while (pushed < n) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				len = db_cap + 2 + $urandom_range(0, span);
				push_level(!last_level, len);
			end else if (r < 90) begin
				len = $urandom_range(1, db_cap + 1);
				push_level(!last_level, len);
			end else begin
				len = $urandom_range(1, 8);
				repeat (len) begin
					lvl = 1'($urandom_range(0, 1));
					push_level(lvl, 1);
				end
			end
			pushed += len;
		end
	endtask

	initial begin
		logic [CFG_W-1:0] db_word;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset limits: seed with the button down, then a cancelled release
		push_level(1'b1, 3);
		push_level(1'b0, 2);
		push_level(1'b1, 1);
		wait_idle();

		// zero limits
		write_reg(REG_DEBOUNCE_TICKS, 24'h000000);
		write_reg(REG_LONG_PRESS_TICKS, 24'h000000);
		settings_used++;
		push_level(1'b1, 1);
		push_level(1'b0, 3);
		push_level(1'b1, 4);
		push_level(1'b0, 1);
		push_level(1'b1, 1);
		push_level(1'b0, 2);
		wait_idle();

		for (int i = 0; i < 9; i++) begin
			db_word = {8'($urandom_range(0, 255)), 16'(db_set[i])};
			write_reg(REG_DEBOUNCE_TICKS, db_word);
			write_reg(REG_LONG_PRESS_TICKS, lp_set[i][HOLD_W-1:0]);
			settings_used++;
			calm = (i == 3);
			push_runs(55);
			wait_idle();
			push_runs(55);
			wait_idle();
		end
		calm = 1'b0;

		wait_idle();
		repeat (5) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected items never arrived", expected_results.size());
			errors++;
		end
		$display("covered %0d ticks over %0d limit settings, %0d result items checked",
			ticks_taken, settings_used, results_checked);
		$display("events seen: %0d presses, %0d long presses, %0d releases",
			presses, long_presses, releases);
		if (errors == 0) begin
			$display("** button_debounce_long_press: PASSED **");
		end else begin
			$display("** button_debounce_long_press: FAILED **");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("** button_debounce_long_press: FAILED **");
		$finish;
	end

endmodule
